FILE: sv/tct_pkg.sv
// shared types and opcode constants for the cell table
package tct_pkg;

    localparam int OP_W = 3;
    localparam int HANDLE_W = 9;
    localparam int COUNT_W = 16;

    localparam logic [OP_W-1:0] OP_ALLOC_WHITE = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_ROOT  = 3'd1;
    localparam logic [OP_W-1:0] OP_ROOT        = 3'd2;
    localparam logic [OP_W-1:0] OP_UNROOT      = 3'd3;
    localparam logic [OP_W-1:0] OP_SHADE       = 3'd4;
    localparam logic [OP_W-1:0] OP_QUERY       = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [COUNT_W-1:0]  count_t;

endpackage

FILE: sv/tricolor_cell_table.sv
// top level: cell table sequencer over slot, root and handle memories
// done rises soonest for allocs, queries and ignored words, and latest for
// unrooting into black with an empty gap
// one word at a time: busy drops with done, so a word starts only once the last is done
// reset clears tops and enters a clearing pass that sets up
// slot, root and rooted tables; busy stays high during the pass
// here the receiver cannot stall: done pulses for one cycle with the result
module tricolor_cell_table #(
    parameter int CELL_SLOTS = 256,
    parameter int ROOT_SLOTS = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [2:0]             opcode,
    input  tct_pkg::handle_t       handle,
    output logic                   done,
    output logic                   status,
    output tct_pkg::handle_t       result_handle,
    output tct_pkg::count_t        root_refs
);
    import tct_pkg::*;

    localparam int TOTAL = CELL_SLOTS + ROOT_SLOTS;
    localparam int SW = $clog2(CELL_SLOTS);
    localparam int RW = $clog2(ROOT_SLOTS);
    localparam int TW = $clog2(TOTAL);
    localparam int ST = SW + 1;
    localparam int RT = RW + 1;
    localparam int BW = (SW > RW) ? SW : RW;
    localparam int CW = TW + 1;

    // states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_OPS   = 4'd5;
    localparam logic [3:0] S_OPW   = 4'd6;
    localparam logic [3:0] S_EXEC  = 4'd7;
    localparam logic [3:0] S_SWAP  = 4'd8;
    localparam logic [3:0] S_SWW   = 4'd9;
    localparam logic [3:0] S_CNT   = 4'd10;
    localparam logic [3:0] S_CNTW  = 4'd11;
    localparam logic [3:0] S_CNTR  = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;
    localparam logic [3:0] S_WRQ   = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [ST-1:0] black_reg, black_next, gs_reg, gs_next, ge_reg, ge_next, we_reg, we_next;
    logic [RT-1:0] re_reg, re_next;
    logic [2:0] op_reg, op_next;
    handle_t h_reg, h_next, rh_reg, rh_next;
    logic st_reg, st_next;
    // fetched values
    handle_t a_reg, a_next, b_reg, b_next, sp_reg, sp_next;
    logic [BW-1:0] idx_reg, idx_next;
    logic rooted_reg, rooted_next;
    count_t cnt_reg, cnt_next, rc_reg, rc_next;
    logic [2:0] step_reg, step_next;
    logic done_reg, done_next;

    // memory ports
    logic s_we; logic [SW-1:0] s_wa, s_ra; handle_t s_wd, s_rd;
    logic r_we; logic [RW-1:0] r_wa, r_ra; logic [HANDLE_W+COUNT_W-1:0] r_wd, r_rd;
    logic b_we; logic [TW-1:0] b_wa, b_ra; logic [BW:0] b_wd, b_rd;

    tct_ram #(.WIDTH(HANDLE_W), .DEPTH(CELL_SLOTS)) u_slot (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
    tct_ram #(.WIDTH(HANDLE_W + COUNT_W), .DEPTH(ROOT_SLOTS)) u_root (
        .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
    // handle memory: rooted flag on top, back index below
    tct_ram #(.WIDTH(BW + 1), .DEPTH(TOTAL)) u_back (
        .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = st_reg;
    assign result_handle = rh_reg;
    assign root_refs = rc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            black_reg <= '0; gs_reg <= '0; ge_reg <= '0; we_reg <= '0; re_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            black_reg <= black_next; gs_reg <= gs_next; ge_reg <= ge_next;
            we_reg <= we_next; re_reg <= re_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; h_reg <= h_next; rh_reg <= rh_next; st_reg <= st_next;
        a_reg <= a_next; b_reg <= b_next; sp_reg <= sp_next; idx_reg <= idx_next;
        rooted_reg <= rooted_next; cnt_reg <= cnt_next; rc_reg <= rc_next;
        step_reg <= step_next;
    end

    // helpers as plain wires
    logic h_ok;
    logic [BW-1:0] bi;
    logic brooted;
    logic cell_live, root_live;
    assign h_ok = ({{(CW-HANDLE_W){1'b0}}, h_reg} < CW'(TOTAL));
    assign bi = b_rd[BW-1:0];
    assign brooted = b_rd[BW];

    // index of the last live root entry
    function automatic logic [RW-1:0] re_next_idx(input logic [RT-1:0] re);
        logic [RT-1:0] t;
        t = re - 1'b1;
        return t[RW-1:0];
    endfunction

    // sequencer: each op issues its reads in turn and its writes in order
    always_comb
    begin
        state_next = state_reg; clr_next = clr_reg;
        black_next = black_reg; gs_next = gs_reg; ge_next = ge_reg;
        we_next = we_reg; re_next = re_reg;
        op_next = op_reg; h_next = h_reg; rh_next = rh_reg; st_next = st_reg;
        a_next = a_reg; b_next = b_reg; sp_next = sp_reg; idx_next = idx_reg;
        rooted_next = rooted_reg; cnt_next = cnt_reg; rc_next = rc_reg;
        step_next = step_reg; done_next = 1'b0;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = '0;
        b_we = 1'b0; b_wa = '0; b_wd = '0; b_ra = '0;
        cell_live = 1'b0; root_live = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg < CW'(CELL_SLOTS))
                begin
                    s_we = 1'b1; s_wa = clr_reg[SW-1:0]; s_wd = HANDLE_W'(clr_reg);
                end
                if (clr_reg < CW'(ROOT_SLOTS))
                begin
                    r_we = 1'b1; r_wa = clr_reg[RW-1:0];
                    r_wd = {HANDLE_W'(CELL_SLOTS + 32'(clr_reg)), {COUNT_W{1'b0}}};
                end
                b_we = 1'b1; b_wa = clr_reg[TW-1:0]; b_wd = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(TOTAL - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next = opcode; h_next = handle; rh_next = handle; st_next = 1'b0;
                    step_next = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // fetch back index of handle, or the allocated slot or root entry
                b_ra = h_reg[TW-1:0];
                s_ra = we_reg[SW-1:0];
                r_ra = re_reg[RW-1:0];
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // capture data for allocs and handle info
                b_ra = h_reg[TW-1:0];
                idx_next = bi; rooted_next = brooted;
                a_next = s_rd; sp_next = r_rd[HANDLE_W+COUNT_W-1:COUNT_W];
                if (op_reg == OP_ALLOC_WHITE)
                begin
                    if (we_reg >= ST'(CELL_SLOTS))
                    begin
                        st_next = 1'b1; state_next = S_CNT;
                    end
                    else
                    begin
                        rh_next = s_rd;
                        if ({1'b0, s_rd} < (HANDLE_W+1)'(TOTAL))
                        begin
                            b_we = 1'b1; b_wa = s_rd[TW-1:0];
                            b_wd = {1'b0, BW'(we_reg)};
                        end
                        we_next = we_reg + 1'b1;
                        state_next = S_CNT;
                    end
                end
                else if (op_reg == OP_ALLOC_ROOT)
                begin
                    if (re_reg >= RT'(ROOT_SLOTS))
                    begin
                        st_next = 1'b1; state_next = S_CNT;
                    end
                    else
                    begin
                        rh_next = r_rd[HANDLE_W+COUNT_W-1:COUNT_W];
                        r_we = 1'b1; r_wa = re_reg[RW-1:0];
                        r_wd = {r_rd[HANDLE_W+COUNT_W-1:COUNT_W], COUNT_W'(1)};
                        if ({1'b0, r_rd[HANDLE_W+COUNT_W-1:COUNT_W]} < (HANDLE_W+1)'(TOTAL))
                        begin
                            b_we = 1'b1; b_wa = r_rd[HANDLE_W+COUNT_W-1:COUNT_W];
                            b_wd = {1'b1, BW'(re_reg)};
                        end
                        re_next = re_reg + 1'b1;
                        state_next = S_CNT;
                    end
                end
                else if (op_reg == OP_ROOT || op_reg == OP_UNROOT || op_reg == OP_SHADE)
                begin
                    state_next = S_DEC;
                end
                else
                begin
                    state_next = S_CNT;
                end
            end
            S_DEC:
            begin
                // read the slot and root entry at the back index
                s_ra = idx_reg[SW-1:0];
                r_ra = idx_reg[RW-1:0];
                state_next = S_OPS;
            end
            S_OPS:
            begin
                // liveness checks against slot tables
                root_live = h_ok && rooted_reg && ({1'b0, idx_reg} < (BW+1)'(re_reg))
                    && (32'(idx_reg) < ROOT_SLOTS)
                    && (r_rd[HANDLE_W+COUNT_W-1:COUNT_W] == h_reg);
                cell_live = h_ok && !rooted_reg && ({1'b0, idx_reg} < (BW+1)'(we_reg))
                    && (32'(idx_reg) < CELL_SLOTS) && (s_rd == h_reg)
                    && !(({1'b0, idx_reg} >= (BW+1)'(black_reg))
                         && ({1'b0, idx_reg} < (BW+1)'(gs_reg)));
                cnt_next = r_rd[COUNT_W-1:0];
                state_next = S_CNT;
                if (op_reg == OP_ROOT)
                begin
                    if (root_live)
                    begin
                        r_we = 1'b1; r_wa = idx_reg[RW-1:0];
                        r_wd = {h_reg, (r_rd[COUNT_W-1:0] == COUNT_MAX) ? COUNT_MAX
                                : r_rd[COUNT_W-1:0] + 1'b1};
                    end
                    else if (cell_live)
                    begin
                        if (re_reg >= RT'(ROOT_SLOTS))
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            step_next = 3'd0; state_next = S_EXEC;
                        end
                    end
                end
                else if (op_reg == OP_UNROOT)
                begin
                    if (root_live)
                    begin
                        if (r_rd[COUNT_W-1:0] > COUNT_W'(1))
                        begin
                            r_we = 1'b1; r_wa = idx_reg[RW-1:0];
                            r_wd = {h_reg, r_rd[COUNT_W-1:0] - 1'b1};
                        end
                        else if (black_reg == gs_reg && we_reg >= ST'(CELL_SLOTS))
                        begin
                            r_we = 1'b1; r_wa = idx_reg[RW-1:0];
                            r_wd = {h_reg, COUNT_W'(1)};
                            st_next = 1'b1;
                        end
                        else
                        begin
                            step_next = 3'd4; state_next = S_EXEC;
                        end
                    end
                end
                else
                begin
                    if (cell_live && ({1'b0, idx_reg} >= (BW+1)'(ge_reg)))
                    begin
                        if ({1'b0, idx_reg} > (BW+1)'(ge_reg))
                        begin
                            step_next = 3'd7; state_next = S_EXEC;
                        end
                        else
                        begin
                            ge_next = ge_reg + 1'b1;
                        end
                    end
                end
            end
            S_EXEC:
            begin
                // issue the read for the next swap step
                unique case (step_reg)
                    3'd0: r_ra = re_reg[RW-1:0];
                    3'd1, 3'd2, 3'd3: s_ra = a_reg[SW-1:0];
                    3'd4, 3'd5, 3'd6: s_ra = a_reg[SW-1:0];
                    default: s_ra = ge_reg[SW-1:0];
                endcase
                if (step_reg == 3'd4)
                begin
                    // blacken: pick the freed slot
                    if (black_reg == gs_reg)
                    begin
                        s_ra = we_reg[SW-1:0];
                    end
                    else
                    begin
                        s_ra = black_reg[SW-1:0];
                    end
                end
                state_next = S_SWAP;
            end
            S_SWAP:
            begin
                // keep the slot read address so its data is still there in S_SWW
                state_next = S_SWW;
                unique case (step_reg)
                    3'd0:
                    begin
                        // root a cell: claim spare root entry
                        sp_next = r_rd[HANDLE_W+COUNT_W-1:COUNT_W];
                        r_we = 1'b1; r_wa = re_reg[RW-1:0]; r_wd = {h_reg, COUNT_W'(1)};
                        b_we = 1'b1; b_wa = h_reg[TW-1:0]; b_wd = {1'b1, BW'(re_reg)};
                        re_next = re_reg + 1'b1;
                        if ({1'b0, idx_reg} < (BW+1)'(black_reg))
                        begin
                            black_next = black_reg - 1'b1;
                            a_next = HANDLE_W'(black_reg - 1'b1);
                            step_next = 3'd1;
                        end
                        else if ({1'b0, idx_reg} < (BW+1)'(ge_reg))
                        begin
                            a_next = HANDLE_W'(gs_reg);
                            gs_next = gs_reg + 1'b1;
                            step_next = 3'd2;
                        end
                        else
                        begin
                            we_next = we_reg - 1'b1;
                            a_next = HANDLE_W'(we_reg - 1'b1);
                            step_next = 3'd3;
                        end
                        state_next = S_EXEC;
                    end
                    3'd1, 3'd2, 3'd3:
                    begin
                        s_ra = a_reg[SW-1:0];
                        state_next = S_SWW;
                    end
                    3'd4:
                    begin
                        if (black_reg == gs_reg)
                        begin
                            s_ra = we_reg[SW-1:0];
                        end
                        else
                        begin
                            s_ra = black_reg[SW-1:0];
                        end
                        state_next = S_SWW;
                    end
                    3'd5, 3'd6:
                    begin
                        s_ra = a_reg[SW-1:0];
                        state_next = S_SWW;
                    end
                    default:
                    begin
                        s_ra = ge_reg[SW-1:0];
                        state_next = S_SWW;
                    end
                endcase
            end
            S_SWW:
            begin
                // data of the slot read in S_EXEC is valid here
                state_next = S_CNT;
                unique case (step_reg)
                    3'd1, 3'd2, 3'd3:
                    begin
                        // move the region-edge handle into idx, spare to edge
                        if ({1'b0, a_reg} != (HANDLE_W+1)'(idx_reg))
                        begin
                            s_we = 1'b1; s_wa = idx_reg[SW-1:0]; s_wd = s_rd;
                            b_next = s_rd;
                            step_next = 3'd5;
                            state_next = S_WRQ;
                        end
                        else
                        begin
                            step_next = 3'd6;
                            state_next = S_WRQ;
                        end
                    end
                    3'd4:
                    begin
                        b_next = s_rd;
                        if (black_reg == gs_reg)
                        begin
                            // rotate white_end <- grey_end <- grey_start <- h
                            a_next = HANDLE_W'(ge_reg);
                            step_next = 3'd5;
                            cnt_next = '0;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            s_we = 1'b1; s_wa = black_reg[SW-1:0]; s_wd = h_reg;
                            b_we = 1'b1; b_wa = h_reg[TW-1:0]; b_wd = {1'b0, BW'(black_reg)};
                            black_next = black_reg + 1'b1;
                            step_next = 3'd1;
                            state_next = S_FIN;
                        end
                    end
                    default:
                    begin
                        // shade: swap slot grey_end into idx, h to grey_end
                        s_we = 1'b1; s_wa = idx_reg[SW-1:0]; s_wd = s_rd;
                        if ({1'b0, s_rd} < (HANDLE_W+1)'(TOTAL))
                        begin
                            b_we = 1'b1; b_wa = s_rd[TW-1:0]; b_wd = {1'b0, BW'(idx_reg)};
                        end
                        step_next = 3'd0;
                        state_next = S_WRQ;
                    end
                endcase
            end
            S_WRQ:
            begin
                // trailing writes of a swap
                state_next = S_CNT;
                if (op_reg == OP_SHADE)
                begin
                    if (step_reg == 3'd0)
                    begin
                        s_we = 1'b1; s_wa = ge_reg[SW-1:0]; s_wd = h_reg;
                        b_we = 1'b1; b_wa = h_reg[TW-1:0]; b_wd = {1'b0, BW'(ge_reg)};
                        ge_next = ge_reg + 1'b1;
                    end
                end
                else if (op_reg == OP_ROOT)
                begin
                    if (step_reg == 3'd5)
                    begin
                        // back index of moved handle
                        if ({1'b0, b_reg} < (HANDLE_W+1)'(TOTAL))
                        begin
                            b_we = 1'b1; b_wa = b_reg[TW-1:0]; b_wd = {1'b0, BW'(idx_reg)};
                        end
                        step_next = 3'd6;
                        state_next = S_WRQ;
                    end
                    else if (step_reg == 3'd6)
                    begin
                        s_we = 1'b1; s_wa = a_reg[SW-1:0]; s_wd = sp_reg;
                        if ({1'b0, sp_reg} < (HANDLE_W+1)'(TOTAL))
                        begin
                            b_we = 1'b1; b_wa = sp_reg[TW-1:0]; b_wd = {1'b0, BW'(a_reg)};
                        end
                    end
                end
                else
                begin
                    // unroot tail: compact root table
                    unique case (step_reg)
                        3'd0:
                        begin
                            // read last root entry
                            r_ra = re_next_idx(re_reg);
                            step_next = 3'd1;
                            state_next = S_WRQ;
                        end
                        3'd1:
                        begin
                            step_next = 3'd2;
                            state_next = S_WRQ;
                            a_next = r_rd[HANDLE_W+COUNT_W-1:COUNT_W];
                            cnt_next = r_rd[COUNT_W-1:0];
                        end
                        3'd2:
                        begin
                            re_next = re_reg - 1'b1;
                            if ((BW+1)'(re_reg - 1'b1) != {1'b0, idx_reg})
                            begin
                                r_we = 1'b1; r_wa = idx_reg[RW-1:0]; r_wd = {a_reg, cnt_reg};
                                if ({1'b0, a_reg} < (HANDLE_W+1)'(TOTAL))
                                begin
                                    b_we = 1'b1; b_wa = a_reg[TW-1:0];
                                    b_wd = {1'b1, BW'(idx_reg)};
                                end
                            end
                            step_next = 3'd3;
                            state_next = S_WRQ;
                        end
                        default:
                        begin
                            r_we = 1'b1; r_wa = re_reg[RW-1:0]; r_wd = {b_reg, COUNT_W'(0)};
                            if ({1'b0, b_reg} < (HANDLE_W+1)'(TOTAL))
                            begin
                                b_we = 1'b1; b_wa = b_reg[TW-1:0]; b_wd = '0;
                            end
                        end
                    endcase
                end
            end
            S_FIN:
            begin
                // blacken with empty gap: rotate through grey and white tops
                state_next = S_FIN;
                unique case (step_reg)
                    3'd5:
                    begin
                        s_ra = ge_reg[SW-1:0];
                        step_next = 3'd6;
                    end
                    3'd6:
                    begin
                        s_ra = ge_reg[SW-1:0];
                        step_next = 3'd7;
                    end
                    3'd7:
                    begin
                        // s_rd = slot[grey_end]
                        s_ra = gs_reg[SW-1:0];
                        if (we_reg != ge_reg)
                        begin
                            s_we = 1'b1; s_wa = we_reg[SW-1:0]; s_wd = s_rd;
                            if ({1'b0, s_rd} < (HANDLE_W+1)'(TOTAL))
                            begin
                                b_we = 1'b1; b_wa = s_rd[TW-1:0]; b_wd = {1'b0, BW'(we_reg)};
                            end
                        end
                        step_next = 3'd2;
                    end
                    3'd2:
                    begin
                        // s_rd = slot[grey_start]
                        if (gs_reg != ge_reg)
                        begin
                            s_we = 1'b1; s_wa = ge_reg[SW-1:0]; s_wd = s_rd;
                            if ({1'b0, s_rd} < (HANDLE_W+1)'(TOTAL))
                            begin
                                b_we = 1'b1; b_wa = s_rd[TW-1:0]; b_wd = {1'b0, BW'(ge_reg)};
                            end
                        end
                        step_next = 3'd3;
                    end
                    3'd3:
                    begin
                        s_we = 1'b1; s_wa = gs_reg[SW-1:0]; s_wd = h_reg;
                        b_we = 1'b1; b_wa = h_reg[TW-1:0]; b_wd = {1'b0, BW'(gs_reg)};
                        black_next = black_reg + 1'b1; gs_next = gs_reg + 1'b1;
                        ge_next = ge_reg + 1'b1; we_next = we_reg + 1'b1;
                        step_next = 3'd1;
                    end
                    default:
                    begin
                        // start root compaction
                        step_next = 3'd0;
                        state_next = S_WRQ;
                    end
                endcase
            end
            S_CNT:
            begin
                // count lookup for the result handle
                b_ra = rh_reg[TW-1:0];
                state_next = S_CNTW;
            end
            S_CNTW:
            begin
                idx_next = bi; rooted_next = brooted;
                r_ra = bi[RW-1:0];
                state_next = S_CNTR;
            end
            default:
            begin
                // S_CNTR: finish and present the word
                if (!st_reg && ({1'b0, rh_reg} < (HANDLE_W+1)'(TOTAL)) && rooted_reg
                    && ({1'b0, idx_reg} < (BW+1)'(re_reg)) && (32'(idx_reg) < ROOT_SLOTS)
                    && (r_rd[HANDLE_W+COUNT_W-1:COUNT_W] == rh_reg))
                begin
                    rc_next = r_rd[COUNT_W-1:0];
                end
                else
                begin
                    rc_next = '0;
                end
                done_next = 1'b1;
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/tct_ram.sv
// generic single port write, single port read ram with registered read
module tct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: tb/sv/tct_checker.sv
// watches the command and result words, predicts the table and compares
`timescale 1ns / 1ps

module tct_checker (
    input  logic              clk,
    input  logic              start,
    input  logic              busy,
    input  logic [2:0]        opcode,
    input  tct_pkg::handle_t  handle,
    input  logic              done,
    input  logic              status,
    input  tct_pkg::handle_t  result_handle,
    input  tct_pkg::count_t   root_refs,
    output int                fail_count,
    output int                pending,
    output int                checked,
    output logic [319:0]      index_known
);
    import tct_pkg::*;

    localparam int CELLS = 256;
    localparam int ROOTS = 64;
    localparam int HANDLES = CELLS + ROOTS;

    typedef struct packed {
        logic    status;
        handle_t handle;
        count_t  count;
    } answer_t;

    answer_t answer_q[$];

    // shadow of the slot, root and handle tables
    int     slot_of[CELLS];
    int     root_of[ROOTS];
    int     count_at[ROOTS];
    bit     is_rooted[HANDLES];
    int     back_idx[HANDLES];
    int     black_lim, grey_lo, grey_hi, white_lim, root_top;

    function automatic bit root_live(int h, output int i);
        if (h >= HANDLES || !is_rooted[h]) return 0;
        i = back_idx[h];
        if (i >= root_top || root_of[i] != h) return 0;
        return 1;
    endfunction

    function automatic bit cell_live(int h, output int i);
        if (h >= HANDLES || is_rooted[h]) return 0;
        i = back_idx[h];
        if (i >= white_lim || slot_of[i] != h) return 0;
        if (i >= black_lim && i < grey_lo) return 0;
        return 1;
    endfunction

    function automatic void set_slot(int i, int h);
        slot_of[i] = h;
        if (h < HANDLES)
        begin
            back_idx[h] = i;
            index_known[h] = 1'b1;
        end
    endfunction

    function automatic void set_root(int i, int h, int c);
        root_of[i] = h;
        count_at[i] = c;
        if (h < HANDLES)
        begin
            back_idx[h] = i;
            index_known[h] = 1'b1;
        end
    endfunction

    // move a live cell into the root table, spare handle takes its slot
    function automatic bit root_cell(int h, int idx);
        int spare;
        if (root_top >= ROOTS) return 0;
        spare = root_of[root_top];
        set_root(root_top, h, 1);
        is_rooted[h] = 1;
        root_top++;
        if (idx < black_lim)
        begin
            black_lim--;
            if (idx < black_lim) set_slot(idx, slot_of[black_lim]);
            set_slot(black_lim, spare);
        end
        else if (idx < grey_hi)
        begin
            if (idx > grey_lo) set_slot(idx, slot_of[grey_lo]);
            set_slot(grey_lo, spare);
            grey_lo++;
        end
        else
        begin
            white_lim--;
            if (idx != white_lim) set_slot(idx, slot_of[white_lim]);
            set_slot(white_lim, spare);
        end
        if (spare < HANDLES) is_rooted[spare] = 0;
        return 1;
    endfunction

    // unrooted handle goes black, taking a gap cell or the first free cell
    function automatic bit blacken(int h, int ridx);
        int freed;
        if (black_lim == grey_lo)
        begin
            if (white_lim >= CELLS) return 0;
            freed = slot_of[white_lim];
            if (white_lim != grey_hi) set_slot(white_lim, slot_of[grey_hi]);
            if (grey_lo != grey_hi) set_slot(grey_hi, slot_of[grey_lo]);
            set_slot(grey_lo, h);
            black_lim++;
            grey_lo++;
            grey_hi++;
            white_lim++;
        end
        else
        begin
            freed = slot_of[black_lim];
            set_slot(black_lim, h);
            black_lim++;
        end
        is_rooted[h] = 0;
        root_top--;
        if (ridx != root_top) set_root(ridx, root_of[root_top], count_at[root_top]);
        set_root(root_top, freed, 0);
        if (freed < HANDLES) is_rooted[freed] = 0;
        return 1;
    endfunction

    function automatic answer_t apply_word(logic [2:0] op, int h);
        answer_t a;
        int idx;
        int rh;
        bit err;
        err = 0;
        rh = h;
        case (op)
            OP_ALLOC_WHITE:
            begin
                if (white_lim >= CELLS) err = 1;
                else
                begin
                    rh = slot_of[white_lim];
                    set_slot(white_lim, rh);
                    if (rh < HANDLES) is_rooted[rh] = 0;
                    white_lim++;
                end
            end
            OP_ALLOC_ROOT:
            begin
                if (root_top >= ROOTS) err = 1;
                else
                begin
                    rh = root_of[root_top];
                    set_root(root_top, rh, 1);
                    if (rh < HANDLES) is_rooted[rh] = 1;
                    root_top++;
                end
            end
            OP_ROOT:
            begin
                if (root_live(h, idx))
                begin
                    if (count_at[idx] < COUNT_MAX) count_at[idx]++;
                end
                else if (cell_live(h, idx))
                begin
                    if (!root_cell(h, idx)) err = 1;
                end
            end
            OP_UNROOT:
            begin
                if (root_live(h, idx))
                begin
                    if (count_at[idx] > 1) count_at[idx]--;
                    else
                    begin
                        count_at[idx] = 0;
                        if (!blacken(h, idx))
                        begin
                            count_at[idx] = 1;
                            err = 1;
                        end
                    end
                end
            end
            OP_SHADE:
            begin
                if (cell_live(h, idx) && idx >= grey_hi)
                begin
                    if (idx > grey_hi)
                    begin
                        set_slot(idx, slot_of[grey_hi]);
                        set_slot(grey_hi, h);
                    end
                    grey_hi++;
                end
            end
            default: ;
        endcase
        a.status = err;
        a.handle = handle_t'(rh);
        if (err || !root_live(rh, idx)) a.count = '0;
        else a.count = count_t'(count_at[idx]);
        return a;
    endfunction

    initial
    begin
        fail_count = 0;
        checked = 0;
        index_known = '0;
        for (int i = 0; i < CELLS; i++) slot_of[i] = i;
        for (int i = 0; i < ROOTS; i++)
        begin
            root_of[i] = CELLS + i;
            count_at[i] = 0;
        end
        for (int i = 0; i < HANDLES; i++)
        begin
            is_rooted[i] = 0;
            back_idx[i] = 0;
        end
        black_lim = 0;
        grey_lo = 0;
        grey_hi = 0;
        white_lim = 0;
        root_top = 0;
    end

    assign pending = answer_q.size();

    // predict on each accepted command word
    always @(posedge clk)
    begin
        if (start && !busy)
            answer_q.push_back(apply_word(opcode, int'(handle)));
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        answer_t want;
        if (done)
        begin
            if (answer_q.size() == 0)
            begin
                $error("result word with nothing expected: handle %0d", result_handle);
                fail_count++;
            end
            else
            begin
                want = answer_q.pop_front();
                checked++;
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (result_handle !== want.handle)
                begin
                    $error("result_handle: expected %0d, got %0d", want.handle,
                           result_handle);
                    fail_count++;
                end
                if (root_refs !== want.count)
                begin
                    $error("root_refs: expected %0d, got %0d", want.count, root_refs);
                    fail_count++;
                end
            end
        end
    end

endmodule

FILE: tb/sv/tb.sv
// testbench top: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module tb;
    import tct_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    logic [2:0]   opcode;
    handle_t      handle;
    logic         done;
    logic         status;
    handle_t      result_handle;
    count_t       root_refs;
    int           fail_count;
    int           pending;
    int           checked;
    logic [319:0] index_known;
    int           op_tally[8];

    tricolor_cell_table dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .handle(handle), .done(done), .status(status),
        .result_handle(result_handle), .root_refs(root_refs)
    );

    tct_checker chk (
        .clk(clk), .start(start), .busy(busy), .opcode(opcode), .handle(handle),
        .done(done), .status(status), .result_handle(result_handle),
        .root_refs(root_refs), .fail_count(fail_count), .pending(pending),
        .checked(checked), .index_known(index_known)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // run limit well above the slowest legal run
    initial
    begin
        #3ms;
        $display("tricolor_cell_table regression: fail");
        $finish;
    end

    // handle for root, unroot and shade: one whose slot index is known,
    // otherwise an out of range handle
    function automatic handle_t pick_handle();
        int h;
        if ($urandom_range(0, 9) != 0)
            for (int t = 0; t < 40; t++)
            begin
                h = $urandom_range(0, 319);
                if (index_known[h]) return handle_t'(h);
            end
        return handle_t'($urandom_range(320, 511));
    endfunction

    // present one word and hold it until busy drops
    task automatic send_word(logic [2:0] op, handle_t h);
        @(posedge clk);
        start <= 1'b1;
        opcode <= op;
        handle <= h;
        op_tally[op]++;
        do @(posedge clk); while (busy);
        start <= 1'b0;
    endtask

    initial
    begin
        int r;
        int gap;
        int burst;
        logic [2:0] op;
        logic [2:0] dir_op[20];
        int dir_h[20];
        dir_op = '{OP_ALLOC_WHITE, OP_ALLOC_WHITE, OP_ALLOC_WHITE,
            OP_SHADE, OP_ALLOC_ROOT, OP_ROOT, OP_ROOT, OP_UNROOT, OP_UNROOT,
            OP_ROOT, OP_UNROOT, OP_UNROOT, OP_QUERY, OP_SHADE, OP_UNROOT,
            3'd6, 3'd7, OP_ROOT, OP_QUERY, OP_SHADE};
        dir_h = '{0, 0, 0, 1, 0, 2, 2, 2, 2, 256, 256, 256, 256, 0, 0,
            511, 320, 400, 0, 1};
        rst_n = 1'b0;
        start = 1'b0;
        opcode = '0;
        handle = '0;
        foreach (op_tally[i]) op_tally[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed words: allocs, rooting, counts, blackening, ignored cases
        for (int i = 0; i < 20; i++) send_word(dir_op[i], handle_t'(dir_h[i]));

        // random words in bursts with random gaps
        burst = 0;
        for (int n = 0; n < 500; n++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 12);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
                repeat (gap) @(posedge clk);
            end
            burst--;
            r = $urandom_range(0, 99);
            if (r < 22) op = OP_ALLOC_WHITE;
            else if (r < 36) op = OP_ALLOC_ROOT;
            else if (r < 56) op = OP_ROOT;
            else if (r < 76) op = OP_UNROOT;
            else if (r < 90) op = OP_SHADE;
            else if (r < 96) op = OP_QUERY;
            else op = 3'($urandom_range(6, 7));
            if (op == OP_ROOT || op == OP_UNROOT || op == OP_SHADE)
                send_word(op, pick_handle());
            else
                send_word(op, handle_t'($urandom_range(0, 511)));
        end

        // drain outstanding results
        while (pending != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("sent %0d words: alloc white %0d, alloc root %0d, root %0d, unroot %0d",
                 op_tally.sum(), op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
        $display("shade %0d, query %0d, unused %0d; %0d results checked",
                 op_tally[4], op_tally[5], op_tally[6] + op_tally[7], checked);
        if (fail_count == 0)
            $display("tricolor_cell_table regression: pass");
        else
            $display("tricolor_cell_table regression: fail");
        $finish;
    end

endmodule
